// ----- hdl/tile_background_pixel_fetch_defines.svh -----
// Assertion macros for the background pixel fetch RTL.
`ifndef TILE_BACKGROUND_PIXEL_FETCH_DEFINES_SVH
`define TILE_BACKGROUND_PIXEL_FETCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TBPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tbpf_pkg.sv -----
// Types and constants of the tile background pixel fetch.
package tbpf_pkg;

    localparam int VRAM_WORDS_DEF = 32768;

    localparam int CMD_W     = 1;
    localparam int VADDR_W   = 15;
    localparam int VDATA_W   = 16;
    localparam int SCROLLX_W = 10;
    localparam int SCROLLY_W = 9;
    localparam int PIXIDX_W  = 10;
    localparam int PAL_W     = 4;
    localparam int COLOR_W   = 4;
    localparam int TILE_W    = 11;
    localparam int FINE_W    = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT_LOG2 = 2'd1;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RENDER = 1'b1;

    localparam logic [CFG_DATA_W-1:0] WLOG_MIN = 3'd5;
    localparam logic [CFG_DATA_W-1:0] WLOG_MAX = 3'd7;
    localparam logic [CFG_DATA_W-1:0] HLOG_MIN = 3'd5;
    localparam logic [CFG_DATA_W-1:0] HLOG_MAX = 3'd6;

    localparam int QUEUE_DEPTH = 2;

    // One classified item on its way to the fetch engine.
    typedef struct packed {
        logic                 is_render;
        logic [VADDR_W-1:0]   addr;      // write address or map entry address
        logic [VDATA_W-1:0]   data;
        logic [FINE_W-1:0]    x_fine;
        logic [FINE_W-1:0]    y_fine;
    } t_cmd;

endpackage

// ----- hdl/tbpf_intf.sv -----
// Valid/ready channel interfaces for input items and pixel results.
interface tbpf_in_if;
    import tbpf_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [VADDR_W-1:0]     vram_address;
    logic [VDATA_W-1:0]     vram_data;
    logic [SCROLLX_W-1:0]   scroll_x;
    logic [SCROLLY_W-1:0]   scroll_y;
    logic [PIXIDX_W-1:0]    pixel_index;

    modport source (
        output valid, command, vram_address, vram_data, scroll_x, scroll_y, pixel_index,
        input  ready
    );
    modport sink (
        input  valid, command, vram_address, vram_data, scroll_x, scroll_y, pixel_index,
        output ready
    );
endinterface

interface tbpf_out_if;
    import tbpf_pkg::*;
    logic               valid;
    logic               ready;
    logic [PAL_W-1:0]   palette_select;
    logic [COLOR_W-1:0] color_index;

    modport source (output valid, palette_select, color_index, input ready);
    modport sink (input valid, palette_select, color_index, output ready);
endinterface

// ----- hdl/tbpf_queue.sv -----
// Small FIFO of classified items between the front end and the fetch engine.
module tbpf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tbpf_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output tbpf_pkg::t_cmd o_head,
    output logic           o_empty
);
    import tbpf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

// ----- hdl/tbpf_front.sv -----
// Front end: config registers, item accept and map address computation.
module tbpf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbpf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tbpf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tbpf_in_if.sink                        i_in,
    input  logic                           i_clearing,
    input  logic                           i_q_full,
    output logic                           o_push,
    output tbpf_pkg::t_cmd                 o_cmd
);
    import tbpf_pkg::*;

    localparam int COL_W = 7;
    localparam int ROW_W = 6;
    localparam int MAP_W = COL_W + ROW_W;

    logic [CFG_DATA_W-1:0] r_wlog, r_hlog;
    logic [CFG_DATA_W-1:0] wlog_c, hlog_c;
    logic [SCROLLX_W:0]    x_sum;
    logic [COL_W-1:0]      col_mask, col;
    logic [ROW_W-1:0]      row_mask, row;
    logic [MAP_W-1:0]      map_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlog <= WLOG_MIN;
            r_hlog <= HLOG_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAP_WIDTH_LOG2:  r_wlog <= i_cfg_data;
                REG_MAP_HEIGHT_LOG2: r_hlog <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        wlog_c = (r_wlog < WLOG_MIN) ? WLOG_MIN : (r_wlog > WLOG_MAX) ? WLOG_MAX : r_wlog;
        hlog_c = (r_hlog < HLOG_MIN) ? HLOG_MIN : (r_hlog > HLOG_MAX) ? HLOG_MAX : r_hlog;

        x_sum    = {1'b0, i_in.scroll_x} + (SCROLLX_W + 1)'(i_in.pixel_index);
        col_mask = COL_W'(((COL_W + 1)'(1) << wlog_c) - (COL_W + 1)'(1));
        row_mask = ROW_W'(((ROW_W + 1)'(1) << hlog_c) - (ROW_W + 1)'(1));
        col      = x_sum[9:3] & col_mask;
        row      = i_in.scroll_y[8:3] & row_mask;
        // col is below 2^wlog, so OR is the add
        map_addr = (MAP_W'(row) << wlog_c) | MAP_W'(col);
    end

    assign i_in.ready = !i_clearing && !i_q_full;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        o_cmd.is_render = (i_in.command == CMD_RENDER);
        o_cmd.addr      = (i_in.command == CMD_RENDER) ? VADDR_W'(map_addr) : i_in.vram_address;
        o_cmd.data      = i_in.vram_data;
        o_cmd.x_fine    = x_sum[FINE_W-1:0];
        o_cmd.y_fine    = i_in.scroll_y[FINE_W-1:0];
    end
endmodule

// ----- hdl/tbpf_back.sv -----
// Fetch engine: video memory, clear sweep, map/pattern sequencer, result register.
`include "tile_background_pixel_fetch_defines.svh"

module tbpf_back #(
    parameter int VRAM_WORDS = tbpf_pkg::VRAM_WORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tbpf_pkg::t_cmd i_head,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_clearing,
    tbpf_out_if.source     o_out
);
    import tbpf_pkg::*;

    localparam int AW = $clog2(VRAM_WORDS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MAP   = 3'd2;
    localparam logic [2:0] ST_PATA  = 3'd3;
    localparam logic [2:0] ST_PATB  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_clr_addr;
    logic [VDATA_W-1:0] r_mem [VRAM_WORDS];
    logic [VDATA_W-1:0] r_rdata;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_addr;
    logic [VDATA_W-1:0] mem_wdata;

    logic [TILE_W-1:0]  r_tile;
    logic [FINE_W-1:0]  r_x_fine, r_y_fine;
    logic [PAL_W-1:0]   r_pal;
    logic [VDATA_W-1:0] r_word_a;
    logic               r_out_valid;
    logic [PAL_W-1:0]   r_out_pal;
    logic [COLOR_W-1:0] r_out_color;

    logic               load_ok, result_load;
    logic [FINE_W-1:0]  sel;
    logic [COLOR_W-1:0] color;

    assign load_ok     = !r_out_valid || o_out.ready;
    assign result_load = (r_state == ST_PATB) && load_ok;
    assign o_pop       = !i_empty && ((r_state == ST_IDLE) || result_load);
    assign o_clearing  = (r_state == ST_CLEAR);

    // leftmost pixel sits in bit 7 of each plane
    assign sel   = ~r_x_fine;
    assign color = {r_rdata[{1'b1, sel}], r_rdata[{1'b0, sel}],
                    r_word_a[{1'b1, sel}], r_word_a[{1'b0, sel}]};

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        unique case (r_state) inside
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
                if (r_clr_addr == AW'(VRAM_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MAP: begin
                mem_re   = 1'b1;
                mem_addr = AW'({r_rdata[TILE_W-1:0], 1'b0, r_y_fine});
                n_state  = ST_PATA;
            end
            ST_PATA: begin
                mem_re   = 1'b1;
                mem_addr = AW'({r_tile, 1'b1, r_y_fine});
                n_state  = ST_PATB;
            end
            ST_IDLE, ST_PATB: begin
                if ((r_state == ST_IDLE) || load_ok) begin
                    n_state = ST_IDLE;
                    if (o_pop) begin
                        mem_addr = AW'(i_head.addr);
                        if (i_head.is_render) begin
                            mem_re  = 1'b1;
                            n_state = ST_MAP;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = i_head.data;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (result_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAP) begin
            r_tile <= r_rdata[TILE_W-1:0];
            r_pal  <= r_rdata[VDATA_W-1 -: PAL_W];
        end
        if (r_state == ST_PATA) begin
            r_word_a <= r_rdata;
        end
        if (o_pop) begin
            r_x_fine <= i_head.x_fine;
            r_y_fine <= i_head.y_fine;
        end
        if (result_load) begin
            r_out_pal   <= r_pal;
            r_out_color <= color;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.palette_select = r_out_pal;
    assign o_out.color_index    = r_out_color;

    `TBPF_ASSERT_NOW(a_single_port, 1'b1, !(mem_we && mem_re), "memory read and write together")
    `TBPF_ASSERT_NOW(a_pop_has_entry, o_pop, !i_empty && (r_state != ST_CLEAR), "bad pop")
    `TBPF_ASSERT_NEXT(a_map_then_pat, r_state == ST_MAP, r_state == ST_PATA, "map read not followed")
    `TBPF_ASSERT_NEXT(a_result_loads, result_load, r_out_valid, "result not registered")
endmodule

// ----- hdl/tile_background_pixel_fetch.sv -----
// Render pixel: map entry read, two pattern word reads, then the result register. The three
// reads share the single memory port; the next item pops as a result loads, held while the
// result register is full. Writes take a single memory write and give no result; a 2-entry
// queue decouples input. Reset: a clearing sweep zeroes video memory, one word per cycle,
// with input ready low; config writes are taken throughout. Both log2 registers reset to 5.
// VRAM_WORDS must be a power of two, not enforced here; addresses wrap on its low bits.
module tile_background_pixel_fetch #(
    parameter int VRAM_WORDS = tbpf_pkg::VRAM_WORDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tbpf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tbpf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tbpf_in_if.sink                         i_in,
    tbpf_out_if.source                      o_out
);
    import tbpf_pkg::*;

    logic push, pop, q_full, q_empty, clearing;
    t_cmd push_cmd, head_cmd;

    tbpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_clearing  (clearing),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    tbpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty)
    );

    tbpf_back #(
        .VRAM_WORDS (VRAM_WORDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_out      (o_out)
    );
endmodule
